>>> rtl/core/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg
// Shared widths, register indexes and types for the planar checker texture.
// ----------------------------------------------------------------------------
package pct_pkg;

    // Coordinate format
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // Derived widths
    localparam int NORM_W  = FRAC_BITS + 2;           // normal components
    localparam int SCALE_W = COORD_WIDTH - 1;         // checker scale
    localparam int REL_W   = COORD_WIDTH + 1;         // hit minus origin
    localparam int PROD_W  = REL_W + NORM_W;          // rel * normal, exact
    localparam int U_W     = 2 * FRAC_BITS + 1;       // low bits of u * scale kept
    localparam int V_W     = 3 * FRAC_BITS + 1;       // low bits of v dot and v * scale
    localparam int LO_W    = V_W / 2;                 // v dot split for the scale multiply
    localparam int HI_W    = V_W - LO_W;
    localparam int CFG_DATA_W = (COORD_WIDTH > NORM_W) ? COORD_WIDTH : NORM_W;
    localparam int CFG_IDX_W  = 3;
    localparam int COLOR_W    = 8;

    localparam logic [COLOR_W-1:0] COLOR_WHITE = 8'd255;
    localparam logic [COLOR_W-1:0] COLOR_BLACK = 8'd0;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NORMAL_X = 3'd0,
        REG_NORMAL_Y = 3'd1,
        REG_NORMAL_Z = 3'd2,
        REG_ORIGIN_X = 3'd3,
        REG_ORIGIN_Y = 3'd4,
        REG_ORIGIN_Z = 3'd5,
        REG_SCALE    = 3'd6
    } pct_reg_t;

    // Plane set-up as seen by the pipeline
    typedef struct packed {
        logic signed [NORM_W-1:0]      normal_x;
        logic signed [NORM_W-1:0]      normal_y;
        logic signed [NORM_W-1:0]      normal_z;
        logic signed [COORD_WIDTH-1:0] origin_x;
        logic signed [COORD_WIDTH-1:0] origin_y;
        logic signed [COORD_WIDTH-1:0] origin_z;
        logic [SCALE_W-1:0]            scale;
        logic                          u_is_y;    // |nx| strictly the largest
    } pct_cfg_t;

    // Magnitude of a normal component; the most negative code maps correctly
    function automatic logic [NORM_W-1:0] norm_mag(input logic [NORM_W-1:0] n);
        norm_mag = n[NORM_W-1] ? (~n + 1'b1) : n;
    endfunction

endpackage

>>> rtl/core/pct_hit_if.sv
// ----------------------------------------------------------------------------
// pct_hit_if
// Hit point channel: valid/ready handshake with the three coordinates.
// ----------------------------------------------------------------------------
interface pct_hit_if
    import pct_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] hit_x;
    logic signed [COORD_WIDTH-1:0] hit_y;
    logic signed [COORD_WIDTH-1:0] hit_z;

    modport source (output valid, output hit_x, output hit_y, output hit_z, input ready);
    modport sink   (input valid, input hit_x, input hit_y, input hit_z, output ready);
endinterface

>>> rtl/core/pct_color_if.sv
// ----------------------------------------------------------------------------
// pct_color_if
// Colour channel: valid/ready handshake with an RGB triple.
// ----------------------------------------------------------------------------
interface pct_color_if
    import pct_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] color_r;
    logic [COLOR_W-1:0] color_g;
    logic [COLOR_W-1:0] color_b;

    modport source (output valid, output color_r, output color_g, output color_b,
                    input ready);
    modport sink   (input valid, input color_r, input color_g, input color_b,
                    output ready);
endinterface

>>> rtl/core/pct_cfg_regs.sv
// ----------------------------------------------------------------------------
// pct_cfg_regs
// Plane configuration registers and the u axis choice derived from the normal.
// ----------------------------------------------------------------------------
module pct_cfg_regs
    import pct_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output pct_cfg_t              cfg
);

    logic signed [NORM_W-1:0]      normal_x_reg, normal_y_reg, normal_z_reg;
    logic signed [COORD_WIDTH-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [SCALE_W-1:0]            scale_reg;
    logic [NORM_W-1:0]             mag_x, mag_y, mag_z;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_x_reg <= '0;
            normal_y_reg <= NORM_W'(1) << FRAC_BITS;
            normal_z_reg <= '0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            scale_reg    <= SCALE_W'(1) << FRAC_BITS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NORMAL_X: normal_x_reg <= NORM_W'(cfg_data);
                REG_NORMAL_Y: normal_y_reg <= NORM_W'(cfg_data);
                REG_NORMAL_Z: normal_z_reg <= NORM_W'(cfg_data);
                REG_ORIGIN_X: origin_x_reg <= COORD_WIDTH'(cfg_data);
                REG_ORIGIN_Y: origin_y_reg <= COORD_WIDTH'(cfg_data);
                REG_ORIGIN_Z: origin_z_reg <= COORD_WIDTH'(cfg_data);
                REG_SCALE:    scale_reg    <= SCALE_W'(cfg_data);
                default:      ;
            endcase
        end
    end

    // u axis is y only when |nx| beats both others; ties fall back to x
    assign mag_x = norm_mag(normal_x_reg);
    assign mag_y = norm_mag(normal_y_reg);
    assign mag_z = norm_mag(normal_z_reg);

    always_comb
    begin
        cfg.normal_x = normal_x_reg;
        cfg.normal_y = normal_y_reg;
        cfg.normal_z = normal_z_reg;
        cfg.origin_x = origin_x_reg;
        cfg.origin_y = origin_y_reg;
        cfg.origin_z = origin_z_reg;
        cfg.scale    = scale_reg;
        cfg.u_is_y   = (mag_x > mag_y) && (mag_x > mag_z);
    end

endmodule

>>> rtl/core/pct_proj.sv
// ----------------------------------------------------------------------------
// pct_proj
// Stages 1 and 2: relative position, axis operand selection and the two
// normal products that make up the v dot product.
// ----------------------------------------------------------------------------
module pct_proj
    import pct_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  pct_cfg_t                      cfg,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] hit_x,
    input  logic signed [COORD_WIDTH-1:0] hit_y,
    input  logic signed [COORD_WIDTH-1:0] hit_z,
    output logic                          s2_valid,
    output logic [U_W-1:0]                s2_u,
    output logic [V_W-1:0]                s2_p1,
    output logic [V_W-1:0]                s2_p2
);

    logic signed [REL_W-1:0]  rel_x, rel_y, rel_z;
    logic signed [REL_W-1:0]  a_next, c_next;
    logic signed [NORM_W-1:0] b_next, d_next;
    logic signed [REL_W-1:0]  u_next;

    logic                     s1_valid_reg;
    logic [U_W-1:0]           s1_u_reg;
    logic signed [REL_W-1:0]  a_reg, c_reg;
    logic signed [NORM_W-1:0] b_reg, d_reg;

    logic signed [PROD_W-1:0] p1, p2;
    logic                     s2_valid_reg;
    logic [U_W-1:0]           s2_u_reg;
    logic [V_W-1:0]           p1_reg, p2_reg;

    // Hit minus origin, exact
    assign rel_x = REL_W'(hit_x) - REL_W'(cfg.origin_x);
    assign rel_y = REL_W'(hit_y) - REL_W'(cfg.origin_y);
    assign rel_z = REL_W'(hit_z) - REL_W'(cfg.origin_z);

    // v = a*b - c*d for the chosen axis pair
    always_comb
    begin
        if (cfg.u_is_y)
        begin
            u_next = rel_y;
            a_next = rel_z;
            b_next = cfg.normal_x;
            c_next = rel_x;
            d_next = cfg.normal_z;
        end
        else
        begin
            u_next = rel_x;
            a_next = rel_y;
            b_next = cfg.normal_z;
            c_next = rel_z;
            d_next = cfg.normal_y;
        end
    end

    // Stage 1 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_u_reg <= U_W'(u_next);
            a_reg    <= a_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
            d_reg    <= d_next;
        end
    end

    // Stage 2: the two normal products
    assign p1 = a_reg * b_reg;
    assign p2 = c_reg * d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_u_reg <= s1_u_reg;
            p1_reg   <= V_W'(p1);
            p2_reg   <= V_W'(p2);
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2_u     = s2_u_reg;
    assign s2_p1    = p1_reg;
    assign s2_p2    = p2_reg;

endmodule

>>> rtl/core/pct_parity.sv
// ----------------------------------------------------------------------------
// pct_parity
// Stages 3 to 5: scale both cell coordinates, take the floor parities and
// form the output colour. Only low bits matter, so all arithmetic wraps.
// ----------------------------------------------------------------------------
module pct_parity
    import pct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic [SCALE_W-1:0] scale,
    input  logic               s2_valid,
    input  logic [U_W-1:0]     s2_u,
    input  logic [V_W-1:0]     s2_p1,
    input  logic [V_W-1:0]     s2_p2,
    output logic               out_valid,
    output logic [COLOR_W-1:0] color
);

    logic [U_W-1:0]             u_prod;
    logic                       s3_valid_reg;
    logic                       s3_pu_reg;
    logic [V_W-1:0]             vdot_reg;

    logic [LO_W+SCALE_W-1:0]    vlo_full;
    logic [HI_W+SCALE_W-1:0]    vhi_full;
    logic                       s4_valid_reg;
    logic                       s4_pu_reg;
    logic [V_W-1:0]             vlo_reg;
    logic [HI_W-1:0]            vhi_reg;

    logic [V_W-1:0]             v_prod;
    logic                       out_valid_reg;
    logic [COLOR_W-1:0]         color_reg;

    // Stage 3: v dot product and u times scale (u parity bit only)
    assign u_prod = s2_u * U_W'(scale);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (adv)
            s3_valid_reg <= s2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_pu_reg <= u_prod[U_W-1];
            vdot_reg  <= s2_p1 - s2_p2;
        end
    end

    // Stage 4: v times scale as two partial products
    assign vlo_full = vdot_reg[LO_W-1:0] * scale;
    assign vhi_full = vdot_reg[V_W-1:LO_W] * scale;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (adv)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_pu_reg <= s3_pu_reg;
            vlo_reg   <= V_W'(vlo_full);
            vhi_reg   <= vhi_full[HI_W-1:0];
        end
    end

    // Stage 5: combine partials, parity of floor(u)+floor(v) picks the colour
    assign v_prod = vlo_reg + {vhi_reg, {LO_W{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            color_reg <= (s4_pu_reg ^ v_prod[V_W-1]) ? COLOR_WHITE : COLOR_BLACK;
    end

    assign out_valid = out_valid_reg;
    assign color     = color_reg;

endmodule

>>> rtl/core/planar_checker_texture_top.sv
// ----------------------------------------------------------------------------
// planar_checker_texture_top
// Checkerboard colour for ray hit points on a configurable plane.
//
//   Channel | Direction | Payload                       | Handshake
//   --------+-----------+-------------------------------+------------
//   hit     | in        | hit_x, hit_y, hit_z (Q16.16)  | valid/ready
//   color   | out       | color_r, color_g, color_b     | valid/ready
//   cfg     | in        | cfg_index, cfg_data           | cfg_we only
//
// One item per cycle while the colour output is not stalled. The colour
// comes from the five register stages of the multiply pipeline (the
// edge that accepts the hit loads the first), in which the v axis scale
// product is split into two partial products.
// Reset clears all stage valid bits and loads the default plane (y-up
// normal, origin at zero, scale 1.0).
// A stalled colour output freezes every stage together; hit.ready follows.
// ----------------------------------------------------------------------------
module planar_checker_texture_top
    import pct_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    pct_hit_if.sink               hit,
    pct_color_if.source           color,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    pct_cfg_t           cfg;
    logic               adv;
    logic               s2_valid;
    logic [U_W-1:0]     s2_u;
    logic [V_W-1:0]     s2_p1, s2_p2;
    logic               out_valid;
    logic [COLOR_W-1:0] shade;

    // Pipeline moves unless a finished item is held at the output
    assign adv       = !out_valid || color.ready;
    assign hit.ready = adv;

    pct_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pct_proj u_proj (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .cfg      (cfg),
        .in_valid (hit.valid),
        .hit_x    (hit.hit_x),
        .hit_y    (hit.hit_y),
        .hit_z    (hit.hit_z),
        .s2_valid (s2_valid),
        .s2_u     (s2_u),
        .s2_p1    (s2_p1),
        .s2_p2    (s2_p2)
    );

    pct_parity u_parity (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .scale     (cfg.scale),
        .s2_valid  (s2_valid),
        .s2_u      (s2_u),
        .s2_p1     (s2_p1),
        .s2_p2     (s2_p2),
        .out_valid (out_valid),
        .color     (shade)
    );

    // Grey-scale result: all three channels equal
    assign color.valid   = out_valid;
    assign color.color_r = shade;
    assign color.color_g = shade;
    assign color.color_b = shade;

endmodule
